// File: hw/rtl/rv32i_subset_core_step_unit_defines.svh
// Assertion macros for the rv32i subset core step unit.
// Bodies refer to clk and rst_n of the including module.
`ifndef RV32I_SUBSET_CORE_STEP_UNIT_DEFINES_SVH
`define RV32I_SUBSET_CORE_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define RVSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RVSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rvss_pkg.sv
// Shared types, sizes and encodings of the rv32i subset core step unit.
// No dependencies.
package rvss_pkg;

    localparam int unsigned INSTR_BYTES = 4096;
    localparam int unsigned DMEM_BYTES  = 4096;
    localparam int unsigned PC_W        = $clog2(INSTR_BYTES);
    localparam int unsigned DM_AW       = $clog2(DMEM_BYTES);
    localparam int unsigned NBANK       = 4;
    localparam int unsigned LANE_W      = $clog2(NBANK);
    localparam int unsigned DM_ROWS     = DMEM_BYTES / NBANK;
    localparam int unsigned ROW_W       = DM_AW - LANE_W;
    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_W      = $clog2(QDEPTH);

    localparam logic [PC_W-1:0] PC_LAST_OK = PC_W'(INSTR_BYTES - 4);

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_SRA  = 7'h20;

    typedef enum logic [3:0] {
        K_ADD, K_XOR, K_ORI, K_SRAI, K_LB, K_LW, K_SB, K_SW,
        K_BEQ, K_JAL, K_LUI, K_BAD
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIP     = 2'd1,
        ST_PC_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } uop_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

// File: hw/rtl/rvss_front.sv
// Front end: decodes each instruction item and queues it for the back end.
// Depends on rvss_pkg.
module rvss_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       instr_word,
    input  rvss_pkg::back_ctl_t ctl,
    output logic              q_valid,
    output rvss_pkg::uop_t    q_head
);
    import rvss_pkg::*;

    uop_t              dec;
    uop_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;

    always_comb
    begin
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        op = instr_word[6:0];
        f3 = instr_word[14:12];
        f7 = instr_word[31:25];
        dec.rd   = instr_word[11:7];
        dec.rs1  = instr_word[19:15];
        dec.rs2  = instr_word[24:20];
        dec.kind = K_BAD;
        dec.imm  = {{20{instr_word[31]}}, instr_word[31:20]};
        unique case (op)
            OPC_OP:
            begin
                if (f7 == F7_ZERO && f3 == F3_ADD)
                    dec.kind = K_ADD;
                else if (f7 == F7_ZERO && f3 == F3_XOR)
                    dec.kind = K_XOR;
            end
            OPC_OPIMM:
            begin
                if (f3 == F3_OR)
                    dec.kind = K_ORI;
                else if (f3 == F3_SR && f7 == F7_SRA)
                    dec.kind = K_SRAI;
            end
            OPC_LOAD:
            begin
                if (f3 == F3_BYTE)
                    dec.kind = K_LB;
                else if (f3 == F3_WORD)
                    dec.kind = K_LW;
            end
            OPC_STORE:
            begin
                dec.imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
                if (f3 == F3_BYTE)
                    dec.kind = K_SB;
                else if (f3 == F3_WORD)
                    dec.kind = K_SW;
            end
            OPC_BRANCH:
            begin
                dec.imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                           instr_word[30:25], instr_word[11:8], 1'b0};
                if (f3 == F3_BEQ)
                    dec.kind = K_BEQ;
            end
            OPC_JAL:
            begin
                dec.imm  = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                            instr_word[20], instr_word[30:21], 1'b0};
                dec.kind = K_JAL;
            end
            OPC_LUI:
            begin
                dec.imm  = {instr_word[31:12], 12'h000};
                dec.kind = K_LUI;
            end
            default:
                dec.kind = K_BAD;
        endcase
    end

    assign in_stall = (count_reg == (QPTR_W+1)'(QDEPTH)) || ctl.clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_head   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push    ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= dec;
    end

endmodule

// File: hw/rtl/rvss_back.sv
// Back end: program counter, register file, banked data memory and result register.
// Depends on rvss_pkg.
module rvss_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  rvss_pkg::uop_t             q_head,
    output rvss_pkg::back_ctl_t        ctl,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [rvss_pkg::PC_W-1:0]  pc_after,
    output logic                       wrote_reg,
    output logic [4:0]                 dest_reg,
    output logic signed [31:0]         dest_value,
    output logic                       wrote_mem,
    output logic [1:0]                 status
);
    import rvss_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_LOAD} state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    uop_t              uop_reg, uop_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              out_valid_reg, out_valid_next;
    logic [PC_W-1:0]   pc_after_reg, pc_after_next;
    logic              wrote_reg_reg, wrote_reg_next;
    logic [4:0]        dest_reg_reg, dest_reg_next;
    logic [31:0]       dest_value_reg, dest_value_next;
    logic              wrote_mem_reg, wrote_mem_next;
    status_t           status_reg, status_next;

    logic [31:0]       rf_mem [32];
    logic [31:0]       rf_valid_reg, rf_valid_next;
    logic [31:0]       rs1_val_reg, rs2_val_reg;

    logic [7:0]        dm_bank [NBANK][DM_ROWS];
    logic [7:0]        dm_rdata_reg [NBANK];
    logic [NBANK-1:0]  dm_we;
    logic              dm_re;
    logic [ROW_W-1:0]  dm_row [NBANK];
    logic [7:0]        dm_wdata [NBANK];

    logic              out_free, pop, done, in_range, is_load, wr_eff;
    logic [PC_W-1:0]   pc_plus4;
    logic [31:0]       mem_addr, load_word, ex_val, res_val;
    logic [PC_W-1:0]   ex_next, res_next;
    logic              ex_wr, ex_st, res_wr, res_st;
    status_t           ex_status, res_status;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign ctl.pop      = pop;
    assign ctl.clearing = (state_reg == S_CLEAR);

    assign pc_plus4 = pc_reg + PC_W'(4);
    assign in_range = (pc_reg <= PC_LAST_OK);
    assign is_load  = (uop_reg.kind == K_LB) || (uop_reg.kind == K_LW);
    assign mem_addr = rs1_val_reg + uop_reg.imm;

    always_comb
    begin
        ex_val    = '0;
        ex_wr     = 1'b0;
        ex_st     = 1'b0;
        ex_next   = pc_plus4;
        ex_status = ST_OK;
        unique case (uop_reg.kind)
            K_ADD:
            begin
                ex_val = rs1_val_reg + rs2_val_reg;
                ex_wr  = 1'b1;
            end
            K_XOR:
            begin
                ex_val = rs1_val_reg ^ rs2_val_reg;
                ex_wr  = 1'b1;
            end
            K_ORI:
            begin
                ex_val = rs1_val_reg | uop_reg.imm;
                ex_wr  = 1'b1;
            end
            K_SRAI:
            begin
                ex_val = $signed(rs1_val_reg) >>> uop_reg.imm[4:0];
                ex_wr  = 1'b1;
            end
            K_LB, K_LW:
                ex_wr = 1'b1;
            K_SB, K_SW:
                ex_st = 1'b1;
            K_BEQ:
            begin
                if (rs1_val_reg == rs2_val_reg)
                    ex_next = pc_reg + uop_reg.imm[PC_W-1:0];
            end
            K_JAL:
            begin
                ex_val  = 32'(pc_reg) + 32'd4;
                ex_wr   = 1'b1;
                ex_next = pc_reg + uop_reg.imm[PC_W-1:0];
            end
            K_LUI:
            begin
                ex_val = uop_reg.imm;
                ex_wr  = 1'b1;
            end
            K_BAD:
                ex_status = ST_SKIP;
            default:
                ex_status = ST_SKIP;
        endcase
        if (!in_range)
        begin
            ex_wr     = 1'b0;
            ex_st     = 1'b0;
            ex_next   = pc_plus4;
            ex_status = ST_PC_RANGE;
        end
    end

    always_comb
    begin
        logic [31:0] raw;
        logic [63:0] rot;
        raw = {dm_rdata_reg[3], dm_rdata_reg[2], dm_rdata_reg[1], dm_rdata_reg[0]};
        rot = {raw, raw} >> {lane_reg, 3'b000};
        if (uop_reg.kind == K_LB)
            load_word = {{24{rot[7]}}, rot[7:0]};
        else
            load_word = rot[31:0];
    end

    always_comb
    begin
        if (state_reg == S_LOAD)
        begin
            res_val    = load_word;
            res_wr     = 1'b1;
            res_st     = 1'b0;
            res_next   = pc_plus4;
            res_status = ST_OK;
        end
        else
        begin
            res_val    = ex_val;
            res_wr     = ex_wr;
            res_st     = ex_st;
            res_next   = ex_next;
            res_status = ex_status;
        end
        wr_eff = res_wr && (uop_reg.rd != 5'd0);
        done   = out_free && (((state_reg == S_EXEC) && !(is_load && in_range))
                              || (state_reg == S_LOAD));
    end

    always_comb
    begin
        logic [LANE_W-1:0] lane;
        logic [LANE_W-1:0] ofs;
        logic [31:0]       sh;
        lane  = mem_addr[LANE_W-1:0];
        dm_re = (state_reg == S_EXEC) && is_load && in_range;
        for (int j = 0; j < NBANK; j++)
        begin
            ofs = LANE_W'(j) - lane;
            sh  = rs2_val_reg >> {ofs, 3'b000};
            if (state_reg == S_CLEAR)
            begin
                dm_row[j]   = clr_row_reg;
                dm_wdata[j] = 8'h00;
                dm_we[j]    = 1'b1;
            end
            else
            begin
                dm_row[j]   = mem_addr[DM_AW-1:LANE_W] + ROW_W'(LANE_W'(j) < lane);
                dm_wdata[j] = sh[7:0];
                dm_we[j]    = done && (state_reg == S_EXEC) && res_st
                              && ((uop_reg.kind == K_SW) || (LANE_W'(j) == lane));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NBANK; j++)
        begin
            if (dm_we[j])
                dm_bank[j][dm_row[j]] <= dm_wdata[j];
            if (dm_re)
                dm_rdata_reg[j] <= dm_bank[j][dm_row[j]];
        end
    end

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (done && wr_eff)
            rf_valid_next[uop_reg.rd] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (done && wr_eff)
            rf_mem[uop_reg.rd] <= res_val;
        if (pop)
        begin
            rs1_val_reg <= rf_valid_reg[q_head.rs1] ? rf_mem[q_head.rs1] : 32'd0;
            rs2_val_reg <= rf_valid_reg[q_head.rs2] ? rf_mem[q_head.rs2] : 32'd0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        pc_next         = pc_reg;
        uop_next        = uop_reg;
        lane_next       = lane_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pc_after_next   = pc_after_reg;
        wrote_reg_next  = wrote_reg_reg;
        dest_reg_next   = dest_reg_reg;
        dest_value_next = dest_value_reg;
        wrote_mem_next  = wrote_mem_reg;
        status_next     = status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(DM_ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    uop_next   = q_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dm_re)
                begin
                    lane_next  = mem_addr[LANE_W-1:0];
                    state_next = S_LOAD;
                end
                else if (done)
                    state_next = S_IDLE;
            end
            S_LOAD:
            begin
                if (done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (done)
        begin
            pc_next         = res_next;
            out_valid_next  = 1'b1;
            pc_after_next   = res_next;
            wrote_reg_next  = wr_eff;
            dest_reg_next   = wr_eff ? uop_reg.rd : 5'd0;
            dest_value_next = wr_eff ? res_val : 32'd0;
            wrote_mem_next  = res_st;
            status_next     = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_row_reg    <= '0;
            pc_reg         <= '0;
            uop_reg        <= '0;
            lane_reg       <= '0;
            rf_valid_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pc_after_reg   <= '0;
            wrote_reg_reg  <= 1'b0;
            dest_reg_reg   <= '0;
            dest_value_reg <= '0;
            wrote_mem_reg  <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            pc_reg         <= pc_next;
            uop_reg        <= uop_next;
            lane_reg       <= lane_next;
            rf_valid_reg   <= rf_valid_next;
            out_valid_reg  <= out_valid_next;
            pc_after_reg   <= pc_after_next;
            wrote_reg_reg  <= wrote_reg_next;
            dest_reg_reg   <= dest_reg_next;
            dest_value_reg <= dest_value_next;
            wrote_mem_reg  <= wrote_mem_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pc_after   = pc_after_reg;
    assign wrote_reg  = wrote_reg_reg;
    assign dest_reg   = dest_reg_reg;
    assign dest_value = dest_value_reg;
    assign wrote_mem  = wrote_mem_reg;
    assign status     = status_reg;

endmodule

// File: hw/rtl/rv32i_subset_core_step_unit.sv
// Top level of the rv32i subset core step unit: front decoder/queue plus back end.
// Depends on rvss_pkg, rvss_front, rvss_back and rv32i_subset_core_step_unit_defines.svh.
//
// Executes one instruction item of a small RV32I subset (ADD, XOR, ORI, SRAI, LB, LW,
// SB, SW, BEQ, JAL, LUI) and returns one result item per instruction. The front end
// decodes and holds up to two items, so input is taken while the back end works and
// while a result waits at the output. The back end takes an item through S_EXEC, and a
// load also through S_LOAD (for the synchronous data memory read). After reset the data memory
// is cleared one row of four bytes per cycle, during which in_stall is high.
`include "rv32i_subset_core_step_unit_defines.svh"

module rv32i_subset_core_step_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                instr_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [rvss_pkg::PC_W-1:0]  pc_after,
    output logic                       wrote_reg,
    output logic [4:0]                 dest_reg,
    output logic signed [31:0]         dest_value,
    output logic                       wrote_mem,
    output logic [1:0]                 status
);
    import rvss_pkg::*;

    back_ctl_t ctl;
    logic      q_valid;
    uop_t      q_head;

    rvss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .instr_word (instr_word),
        .ctl        (ctl),
        .q_valid    (q_valid),
        .q_head     (q_head)
    );

    rvss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pc_after   (pc_after),
        .wrote_reg  (wrote_reg),
        .dest_reg   (dest_reg),
        .dest_value (dest_value),
        .wrote_mem  (wrote_mem),
        .status     (status)
    );

    `RVSS_ASSERT_NOW(a_clear_blocks_input, ctl.clearing, in_stall, "input taken during clear")
    `RVSS_ASSERT_NOW(a_no_pop_when_empty, ctl.pop, q_valid, "pop from empty queue")
    `RVSS_ASSERT_NOW(a_skip_no_effect, out_valid && (status != ST_OK), !wrote_reg && !wrote_mem, "side effect on skipped item")
    `RVSS_ASSERT_NOW(a_write_not_x0, out_valid && wrote_reg, (dest_reg != 5'd0) && !wrote_mem, "bad register write report")

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for rv32i_subset_core_step_unit: directed and random instruction items with a
// self-tracking model of PC, register file and data memory. Depends on rvss_pkg and the RTL.
module tb;
    import rvss_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1074;
    localparam int MAX_GAP        = 18;
    localparam int LONG_HOLD      = 120;
    localparam int HOLD_AT_RESULT = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [PC_W-1:0] pc_after;
        logic            wrote_reg;
        logic [4:0]      dest_reg;
        logic [31:0]     dest_value;
        logic            wrote_mem;
        status_t         status;
    } step_result_t;

    class step_scoreboard;
        step_result_t    predicted_steps[$];
        logic [PC_W-1:0] pc;
        logic [31:0]     regs[32];
        logic [7:0]      dmem[DMEM_BYTES];
        int              mismatches;
        int              checked;
        int              status_count[3];
        int              stores;
        int              reg_writes;

        function new();
            pc = '0;
            foreach (regs[i])
                regs[i] = '0;
            foreach (dmem[i])
                dmem[i] = '0;
            foreach (status_count[i])
                status_count[i] = 0;
            mismatches = 0;
            checked    = 0;
            stores     = 0;
            reg_writes = 0;
        endfunction

        function int pending();
            return predicted_steps.size();
        endfunction

        function step_result_t execute_instr(logic [31:0] w);
            step_result_t      r;
            logic [6:0]        op;
            logic [4:0]        rd;
            logic [2:0]        f3;
            logic [6:0]        f7;
            logic [31:0]       a;
            logic [31:0]       b;
            logic [31:0]       val;
            logic [31:0]       addr;
            logic [31:0]       imm;
            logic [DM_AW-1:0]  ba;
            logic [PC_W-1:0]   next_pc;
            logic              wr;
            logic              st;
            status_t           stat;
            op      = w[6:0];
            rd      = w[11:7];
            f3      = w[14:12];
            f7      = w[31:25];
            a       = regs[w[19:15]];
            b       = regs[w[24:20]];
            next_pc = pc + PC_W'(4);
            wr      = 1'b0;
            st      = 1'b0;
            val     = '0;
            stat    = ST_OK;
            if (pc > PC_LAST_OK)
                stat = ST_PC_RANGE;
            else if (op == OPC_OP && f7 == F7_ZERO && (f3 == F3_ADD || f3 == F3_XOR))
            begin
                val = (f3 == F3_ADD) ? a + b : a ^ b;
                wr  = 1'b1;
            end
            else if (op == OPC_OPIMM && f3 == F3_OR)
            begin
                val = a | {{20{w[31]}}, w[31:20]};
                wr  = 1'b1;
            end
            else if (op == OPC_OPIMM && f3 == F3_SR && f7 == F7_SRA)
            begin
                val = 32'($signed(a) >>> w[24:20]);
                wr  = 1'b1;
            end
            else if (op == OPC_LOAD && (f3 == F3_BYTE || f3 == F3_WORD))
            begin
                addr = a + {{20{w[31]}}, w[31:20]};
                if (f3 == F3_BYTE)
                begin
                    ba  = DM_AW'(addr);
                    val = {{24{dmem[ba][7]}}, dmem[ba]};
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        ba = DM_AW'(addr + 32'(k));
                        val[8*k +: 8] = dmem[ba];
                    end
                end
                wr = 1'b1;
            end
            else if (op == OPC_STORE && (f3 == F3_BYTE || f3 == F3_WORD))
            begin
                addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
                for (int k = 0; k < ((f3 == F3_BYTE) ? 1 : 4); k++)
                begin
                    ba = DM_AW'(addr + 32'(k));
                    dmem[ba] = b[8*k +: 8];
                end
                st = 1'b1;
            end
            else if (op == OPC_BRANCH && f3 == F3_BEQ)
            begin
                imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                if (a == b)
                    next_pc = pc + imm[PC_W-1:0];
            end
            else if (op == OPC_JAL)
            begin
                imm     = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                val     = 32'(pc) + 32'd4;
                wr      = 1'b1;
                next_pc = pc + imm[PC_W-1:0];
            end
            else if (op == OPC_LUI)
            begin
                val = {w[31:12], 12'h000};
                wr  = 1'b1;
            end
            else
                stat = ST_SKIP;

            if (wr && rd != 5'd0)
                regs[rd] = val;
            else
            begin
                wr  = 1'b0;
                rd  = '0;
                val = '0;
            end
            pc = next_pc;

            r.pc_after   = next_pc;
            r.wrote_reg  = wr;
            r.dest_reg   = rd;
            r.dest_value = val;
            r.wrote_mem  = st;
            r.status     = stat;
            return r;
        endfunction

        function void note_input(logic [31:0] word);
            step_result_t r;
            r = execute_instr(word);
            status_count[int'(r.status)]++;
            stores     += r.wrote_mem;
            reg_writes += r.wrote_reg;
            predicted_steps.push_back(r);
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            if (predicted_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result pc=%h wr=%b rd=%0d val=%h mem=%b st=%0d",
                             got.pc_after, got.wrote_reg, got.dest_reg, got.dest_value,
                             got.wrote_mem, got.status);
                return;
            end
            want = predicted_steps.pop_front();
            checked++;
            if (got.pc_after !== want.pc_after || got.wrote_reg !== want.wrote_reg ||
                got.dest_reg !== want.dest_reg || got.dest_value !== want.dest_value ||
                got.wrote_mem !== want.wrote_mem || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("ERROR: item %0d expected pc=%h wr=%b rd=%0d val=%h mem=%b st=%0d",
                             checked, want.pc_after, want.wrote_reg, want.dest_reg,
                             want.dest_value, want.wrote_mem, want.status);
                    $display("       actual       pc=%h wr=%b rd=%0d val=%h mem=%b st=%0d",
                             got.pc_after, got.wrote_reg, got.dest_reg, got.dest_value,
                             got.wrote_mem, got.status);
                end
            end
        endfunction
    endclass

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    logic [31:0]             instr_word = '0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic [PC_W-1:0]         pc_after;
    logic                    wrote_reg;
    logic [4:0]              dest_reg;
    logic signed [31:0]      dest_value;
    logic                    wrote_mem;
    logic [1:0]              status;

    step_scoreboard sb;
    int             items_sent    = 0;
    int             results_taken = 0;
    int             idle_cycles   = 0;
    bit             sink_holding  = 1'b0;

    rv32i_subset_core_step_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .instr_word (instr_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pc_after   (pc_after),
        .wrote_reg  (wrote_reg),
        .dest_reg   (dest_reg),
        .dest_value (dest_value),
        .wrote_mem  (wrote_mem),
        .status     (status)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // taken BEQ x0,x0 from the current PC to an absolute target
    function automatic logic [31:0] branch_to(logic [PC_W-1:0] target);
        logic [PC_W-1:0] offset;
        offset = target - sb.pc;
        return enc_b({1'b0, offset}, 5'd0, 5'd0, F3_BEQ);
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom());
    endfunction

    function automatic logic [31:0] bad_instr();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0:
            begin
                w[6:0] = OPC_OP;
                if (w[31:25] == F7_ZERO && (w[14:12] == F3_ADD || w[14:12] == F3_XOR))
                    w[25] = 1'b1;
            end
            1:
            begin
                w[6:0] = OPC_OPIMM;
                if (w[14:12] == F3_OR)
                    w[12] = 1'b1;
                else if (w[14:12] == F3_SR && w[31:25] == F7_SRA)
                    w[25] = 1'b1;
            end
            2:
            begin
                w[6:0] = OPC_LOAD;
                if (w[14:12] == F3_BYTE || w[14:12] == F3_WORD)
                    w[12] = 1'b1;
            end
            3:
            begin
                w[6:0] = OPC_STORE;
                if (w[14:12] == F3_BYTE || w[14:12] == F3_WORD)
                    w[12] = 1'b1;
            end
            4:
            begin
                w[6:0] = OPC_BRANCH;
                if (w[14:12] == F3_BEQ)
                    w[12] = 1'b1;
            end
            default:
            begin
                while (w[6:0] inside {OPC_OP, OPC_OPIMM, OPC_LOAD, OPC_STORE, OPC_BRANCH,
                                      OPC_JAL, OPC_LUI})
                    w[6:0] = 7'($urandom());
            end
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_instr();
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [11:0] imm12;
        logic [31:0] bits;
        kind_t       kind;
        rd    = pick_reg();
        rs1   = pick_reg();
        rs2   = pick_reg();
        imm12 = 12'($urandom());
        bits  = $urandom();
        kind  = kind_t'($urandom_range(0, int'(K_BAD)));
        if ($urandom_range(0, 11) == 0)
            return bits;
        // small window at the bottom of memory so loads see earlier stores
        if (kind inside {K_LB, K_LW, K_SB, K_SW} && $urandom_range(0, 1) == 1)
        begin
            rs1   = '0;
            imm12 = 12'($urandom_range(0, 63));
        end
        case (kind)
            K_ADD:  return enc_r(F7_ZERO, rs2, rs1, F3_ADD, rd, OPC_OP);
            K_XOR:  return enc_r(F7_ZERO, rs2, rs1, F3_XOR, rd, OPC_OP);
            K_ORI:  return enc_i(imm12, rs1, F3_OR, rd, OPC_OPIMM);
            K_SRAI: return enc_i({F7_SRA, imm12[4:0]}, rs1, F3_SR, rd, OPC_OPIMM);
            K_LB:   return enc_i(imm12, rs1, F3_BYTE, rd, OPC_LOAD);
            K_LW:   return enc_i(imm12, rs1, F3_WORD, rd, OPC_LOAD);
            K_SB:   return enc_s(imm12, rs2, rs1, F3_BYTE);
            K_SW:   return enc_s(imm12, rs2, rs1, F3_WORD);
            K_BEQ:
            begin
                if ($urandom_range(0, 15) == 0)
                    return branch_to(PC_LAST_OK + PC_W'(2 * $urandom_range(0, 1)));
                if (bits[31])
                    rs2 = rs1;
                return enc_b({bits[12:1], 1'b0}, rs2, rs1, F3_BEQ);
            end
            K_JAL:  return enc_j({bits[20:1], 1'b0}, rd);
            K_LUI:  return {bits[31:12], rd, OPC_LUI};
            default: return bad_instr();
        endcase
    endfunction

    task automatic send_instr(input logic [31:0] word);
        int gap;
        gap = (sink_holding || (items_sent / 64) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        instr_word <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(word);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : instr_source
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_instr({20'hFFFFF, 5'd1, OPC_LUI});
        send_instr(enc_i(12'h7FF, 5'd0, F3_OR, 5'd2, OPC_OPIMM));
        send_instr(enc_i(12'hFFF, 5'd1, F3_OR, 5'd3, OPC_OPIMM));
        send_instr(enc_r(F7_ZERO, 5'd2, 5'd3, F3_ADD, 5'd4, OPC_OP));
        send_instr(enc_r(F7_ZERO, 5'd1, 5'd3, F3_XOR, 5'd5, OPC_OP));
        send_instr(enc_i({F7_SRA, 5'd31}, 5'd1, F3_SR, 5'd6, OPC_OPIMM));
        send_instr(enc_i({F7_SRA, 5'd0}, 5'd5, F3_SR, 5'd7, OPC_OPIMM));
        // word access straddling the top of data memory
        send_instr(enc_s(12'hFFF, 5'd5, 5'd0, F3_WORD));
        send_instr(enc_i(12'hFFF, 5'd0, F3_WORD, 5'd8, OPC_LOAD));
        send_instr(enc_i(12'hFFF, 5'd0, F3_BYTE, 5'd9, OPC_LOAD));
        send_instr(enc_s(12'h7FF, 5'd4, 5'd6, F3_BYTE));
        send_instr(enc_i(12'h7FF, 5'd6, F3_BYTE, 5'd31, OPC_LOAD));
        send_instr(enc_r(F7_ZERO, 5'd3, 5'd3, F3_ADD, 5'd0, OPC_OP));
        send_instr(enc_r(F7_SRA, 5'd2, 5'd1, F3_ADD, 5'd10, OPC_OP));
        send_instr(enc_i(12'h123, 5'd1, F3_ADD, 5'd10, OPC_OPIMM));
        send_instr(enc_i({F7_ZERO, 5'd3}, 5'd1, F3_SR, 5'd10, OPC_OPIMM));
        send_instr(32'h0000_0000);
        send_instr(32'hFFFF_FFFF);
        send_instr(enc_b(13'h0010, 5'd2, 5'd1, F3_BEQ));
        send_instr(enc_j(21'h100000, 5'd31));
        send_instr(enc_j(21'h0FFFFE, 5'd0));
        // JAL at the last word links the unwrapped PC+4
        send_instr(branch_to(PC_LAST_OK));
        send_instr(enc_j(21'h000000, 5'd5));
        send_instr(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
        send_instr(branch_to(PC_LAST_OK + PC_W'(2)));
        send_instr({20'h12345, 5'd9, OPC_LUI});
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain();
            send_instr(random_instr());
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items: %0d executed, %0d unsupported, %0d with PC out of range.",
                 items_sent, sb.status_count[ST_OK], sb.status_count[ST_SKIP],
                 sb.status_count[ST_PC_RANGE]);
        $display("Checked %0d result items; %0d register writes, %0d stores, %0d mismatches.",
                 sb.checked, sb.reg_writes, sb.stores, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : result_sink
        int           hold;
        step_result_t got;
        @(posedge rst_n);
        forever
        begin
            if (results_taken == HOLD_AT_RESULT)
            begin
                hold         = LONG_HOLD;
                sink_holding = 1'b1;
            end
            else
                hold = ((results_taken / 80) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall    <= 1'b0;
            sink_holding  = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = '{pc_after, wrote_reg, dest_reg, dest_value, wrote_mem, status_t'(status)};
            sb.check_result(got);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
